### hdl/csvt_pkg.sv
// Shared types and constants for the CSV field tokenizer.
package csvt_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam logic [ByteW-1:0] MaxFieldLenReset = 8'd255;

  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_SKIP   = 3'd4
  } csvt_mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_ERROR  = 2'd3
  } csvt_kind_e;

  typedef struct packed {
    logic             valid;
    csvt_kind_e       kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] len;
  } csvt_result_t;

  function automatic logic is_delim(logic [ByteW-1:0] b);
    return (b == ChComma) || (b == ChCr) || (b == ChLf) || (b == ChNul);
  endfunction

endpackage

### hdl/csvt_parser.sv
// Parse state (mode and content count) and the per-byte decode logic.
module csvt_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [csvt_pkg::ByteW-1:0] byte_i,
  input  logic [csvt_pkg::ByteW-1:0] max_len_i,
  output csvt_pkg::csvt_result_t     res_o
);
  import csvt_pkg::*;

  csvt_mode_e       mode_q, mode_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] count_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_START;
      count_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  // A new field always starts counting from zero
  assign count_cur = (mode_q == MODE_START) ? '0 : count_q;

  always_comb begin
    mode_d     = mode_q;
    count_d    = count_cur;
    res_o      = '0;
    res_o.kind = KIND_BYTE;
    unique case (mode_q)
      MODE_START, MODE_PLAIN, MODE_QUOTED, MODE_QSEEN: begin
        priority if ((mode_q == MODE_START || mode_q == MODE_QUOTED) && byte_i == ChQuote) begin
          mode_d = (mode_q == MODE_START) ? MODE_QUOTED : MODE_QSEEN;
        end else if ((mode_q == MODE_QUOTED) ? (byte_i == ChNul) : is_delim(byte_i)) begin
          // end of field: comma keeps the record open, others close it
          res_o.valid = 1'b1;
          res_o.len   = count_cur;
          count_d     = '0;
          if (byte_i == ChComma) begin
            res_o.kind = KIND_FIELD;
            mode_d     = MODE_START;
          end else begin
            res_o.kind = KIND_RECORD;
            mode_d     = (byte_i == ChNul) ? MODE_START : MODE_SKIP;
          end
        end else if (mode_q == MODE_QSEEN && byte_i != ChQuote) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_ERROR;
          mode_d      = MODE_SKIP;
          count_d     = '0;
        end else if (count_cur >= max_len_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_ERROR;
          mode_d      = MODE_SKIP;
          count_d     = '0;
        end else begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BYTE;
          res_o.data  = byte_i;
          count_d     = count_cur + 8'd1;
          mode_d      = (mode_q == MODE_START || mode_q == MODE_PLAIN) ? MODE_PLAIN
                                                                       : MODE_QUOTED;
        end
      end
      default: begin
        // skip until end of line buffer
        if (byte_i == ChNul) begin
          mode_d  = MODE_START;
          count_d = '0;
        end
      end
    endcase
  end

endmodule

### hdl/csv_field_tokenizer_unit.sv
// CSV field tokenizer: one line byte in, at most one token out per item.
// Takes one item per clock cycle sustained while the output is not stalled. The
// item sits in an input register, the parse mode and field count update as it
// moves on, and the result waits in an output register, so a stalled output
// only holds the input side once both registers are full. Writes to
// max_field_len take effect on the next item.
module csv_field_tokenizer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csvt_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [csvt_pkg::ByteW-1:0] in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [csvt_pkg::KindW-1:0] out_kind_o,
  output logic [csvt_pkg::ByteW-1:0] out_byte_o,
  output logic [csvt_pkg::ByteW-1:0] field_length_o
);
  import csvt_pkg::*;

  logic [ByteW-1:0] max_field_len_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  logic [KindW-1:0] out_kind_q;
  logic [ByteW-1:0] out_byte_q;
  logic [ByteW-1:0] out_len_q;
  logic             advance;
  csvt_result_t     res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_field_len_q <= MaxFieldLenReset;
    end else if (cfg_we_i) begin
      max_field_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  csvt_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .max_len_i (max_field_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_kind_q <= res.kind;
      out_byte_q <= res.data;
      out_len_q  <= res.len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_byte_o     = out_byte_q;
  assign field_length_o = out_len_q;

endmodule

### hdl/csvt_checker.sv
// Port-level checks for the CSV field tokenizer, bound to the top level.
module csvt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [csvt_pkg::KindW-1:0] out_kind_i,
  input logic [csvt_pkg::ByteW-1:0] out_byte_i,
  input logic [csvt_pkg::ByteW-1:0] field_length_i
);
  import csvt_pkg::*;

  // Held result must not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_kind_i) && $stable(out_byte_i) && $stable(field_length_i))
    else $error("result changed while stalled");

  // Input side only stalls behind a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  a_byte_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_BYTE |-> field_length_i == '0)
    else $error("content item carries a length");

  a_end_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_BYTE |-> out_byte_i == '0)
    else $error("non-content item carries a byte");

  a_err_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_ERROR |-> field_length_i == '0)
    else $error("error item carries a length");

endmodule

bind csv_field_tokenizer_unit csvt_checker u_csvt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_kind_i     (out_kind_o),
  .out_byte_i     (out_byte_o),
  .field_length_i (field_length_o)
);

### dv/tb_csv_field_tokenizer_unit.sv
// Self-checking testbench for the CSV field tokenizer: directed table, then random records.
module tb_csv_field_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import csvt_pkg::*;

  localparam int unsigned RandItems  = 850;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 6;

  typedef struct packed {
    csvt_kind_e       kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] len;
  } token_t;

  typedef struct packed {
    logic             is_cfg;
    logic             fixed;
    logic             yields;
    logic [ByteW-1:0] val;
    csvt_kind_e       kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] len;
  } stim_row_t;

  typedef enum int {TERM_NUL, TERM_CR, TERM_LF, TERM_CRLF} term_e;

  localparam int unsigned NumDir = 28;
  // Rows with fixed set carry the expected token; the others go to the predictor.
  localparam stim_row_t DirRows [NumDir] = '{
    '{1'b0, 1'b1, 1'b1, ChNul,   KIND_RECORD, 8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b1, ChNul,   KIND_RECORD, 8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b1, 8'h61,   KIND_BYTE,   8'h61,   8'd0},
    '{1'b0, 1'b1, 1'b1, 8'hFF,   KIND_BYTE,   8'hFF,   8'd0},
    '{1'b0, 1'b1, 1'b1, ChComma, KIND_FIELD,  8'h00,   8'd2},
    '{1'b0, 1'b1, 1'b1, ChNul,   KIND_RECORD, 8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChQuote, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, ChComma, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, ChLf,    KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChQuote, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, ChQuote, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChQuote, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, ChComma, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChQuote, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChQuote, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b1, 8'h79,   KIND_ERROR,  8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChNul,   KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChQuote, KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, 8'h71,   KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, ChNul,   KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, 8'h62,   KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b0, 1'b0, ChCr,    KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, 8'h41,   KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChNul,   KIND_BYTE,   8'h00,   8'd0},
    '{1'b1, 1'b0, 1'b0, 8'd0,    KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b1, 8'h61,   KIND_ERROR,  8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b0, ChNul,   KIND_BYTE,   8'h00,   8'd0},
    '{1'b0, 1'b1, 1'b1, ChComma, KIND_FIELD,  8'h00,   8'd0}
  };

  localparam logic [ByteW-1:0] Specials [5] = '{ChQuote, ChComma, ChLf, ChCr, ChNul};

  logic             clk_i       = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [ByteW-1:0] cfg_wdata   = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] in_byte     = '0;
  logic             out_valid_o;
  logic             out_ready   = 1'b0;
  logic [KindW-1:0] out_kind_o;
  logic [ByteW-1:0] out_byte_o;
  logic [ByteW-1:0] field_length_o;

  // Sideband that travels with each item: a typed expectation from the table.
  logic   typed_en     = 1'b0;
  logic   typed_yields = 1'b0;
  token_t typed_tok    = '0;

  // Predictor state
  csvt_mode_e       mode      = MODE_START;
  logic [ByteW-1:0] fld_count = '0;
  logic [ByteW-1:0] max_len   = MaxFieldLenReset;

  token_t      expected_tokens [$];
  int unsigned n_items   = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg     = 0;
  int unsigned n_errors  = 0;
  int unsigned cycles    = 0;
  bit          tx_idle   = 1'b0;
  bit          rx_stall  = 1'b0;
  int unsigned stall_left = 0;

  csv_field_tokenizer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .field_length_o (field_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Content byte, or an error once the field already holds max_len bytes.
  function automatic bit append_content(input logic [ByteW-1:0] b, input csvt_mode_e next,
                                        output token_t tok);
    tok = '{KIND_BYTE, 8'h00, 8'h00};
    if (fld_count >= max_len) begin
      mode      = MODE_SKIP;
      fld_count = '0;
      tok.kind  = KIND_ERROR;
    end else begin
      fld_count = fld_count + 8'd1;
      mode      = next;
      tok.data  = b;
    end
    return 1'b1;
  endfunction

  function automatic bit close_field(input logic [ByteW-1:0] b, output token_t tok);
    tok       = '{KIND_RECORD, 8'h00, fld_count};
    fld_count = '0;
    if (b == ChComma) begin
      tok.kind = KIND_FIELD;
      mode     = MODE_START;
    end else begin
      mode = (b == ChNul) ? MODE_START : MODE_SKIP;
    end
    return 1'b1;
  endfunction

  function automatic bit tokenize(input logic [ByteW-1:0] b, output token_t tok);
    bit delim;
    delim = (b == ChComma) || (b == ChCr) || (b == ChLf) || (b == ChNul);
    tok   = '{KIND_BYTE, 8'h00, 8'h00};
    case (mode)
      MODE_START, MODE_PLAIN: begin
        if (mode == MODE_START) begin
          fld_count = '0;
          if (b == ChQuote) begin
            mode = MODE_QUOTED;
            return 1'b0;
          end
        end
        if (delim) return close_field(b, tok);
        return append_content(b, MODE_PLAIN, tok);
      end
      MODE_QUOTED: begin
        if (b == ChQuote) begin
          mode = MODE_QSEEN;
          return 1'b0;
        end
        if (b == ChNul) return close_field(b, tok);
        return append_content(b, MODE_QUOTED, tok);
      end
      MODE_QSEEN: begin
        if (b == ChQuote) return append_content(b, MODE_QUOTED, tok);
        if (delim) return close_field(b, tok);
        mode      = MODE_SKIP;
        fld_count = '0;
        tok.kind  = KIND_ERROR;
        return 1'b1;
      end
      default: begin
        if (b == ChNul) begin
          mode      = MODE_START;
          fld_count = '0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Check results and predict accepted items at the rising edge.
  always @(posedge clk_i) begin
    token_t got, want, pred;
    bit     has;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end else if (rst_n) begin
      if (out_valid_o && out_ready) begin
        n_results++;
        got = '{csvt_kind_e'(out_kind_o), out_byte_o, field_length_o};
        if (expected_tokens.size() == 0) begin
          $error("unexpected result: out_kind %0d out_byte %0h field_length %0d",
                 got.kind, got.data, got.len);
          n_errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind != want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
            n_errors++;
          end
          if (got.data != want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, got.data);
            n_errors++;
          end
          if (got.len != want.len) begin
            $error("field_length: expected %0d, got %0d", want.len, got.len);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        has = tokenize(in_byte, pred);
        if (typed_en) begin
          has  = typed_yields;
          pred = typed_tok;
        end
        if (has) expected_tokens.push_back(pred);
      end
    end
  end

  // Receiver back-pressure in bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_stall && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic put_byte(input logic [ByteW-1:0] b, input bit fixed = 1'b0,
                          input bit yields = 1'b0, input token_t tok = '0);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      in_byte  <= ByteW'($urandom_range(0, 255));
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid     <= 1'b1;
    in_byte      <= b;
    typed_en     <= fixed;
    typed_yields <= yields;
    typed_tok    <= tok;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
  endtask

  // Hold the input until every token is out, then let the pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [ByteW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cfg_wdata <= ByteW'($urandom_range(0, 255));
    max_len = v;
    n_cfg++;
  endtask

  function automatic logic [ByteW-1:0] noisy_byte();
    if ($urandom_range(0, 2) == 0) return Specials[$urandom_range(0, 4)];
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic logic [ByteW-1:0] plain_byte(input bit first);
    logic [ByteW-1:0] b;
    if (!first && $urandom_range(0, 7) == 0) return ChQuote;
    do b = ByteW'($urandom_range(1, 255));
    while (b == ChComma || b == ChCr || b == ChLf || (first && b == ChQuote));
    return b;
  endfunction

  // One record of well-formed fields, with the odd broken closing quote and, if asked, an overlong first field.
  task automatic send_record(input bit overlong);
    int unsigned nf, flen, short_max;
    bit          quoted, open_end;
    term_e       term;
    logic [ByteW-1:0] b;
    nf        = $urandom_range(1, 4);
    open_end  = 1'b0;
    short_max = (max_len < 4) ? max_len + 1 : 5;
    term      = term_e'($urandom_range(0, 3));
    for (int f = 0; f < nf; f++) begin
      quoted = $urandom_range(0, 1);
      if (overlong && f == 0) flen = max_len + 1;
      else if (max_len < 16 && $urandom_range(0, 7) == 0) flen = $urandom_range(0, max_len + 1);
      else flen = $urandom_range(0, short_max);
      if (quoted) put_byte(ChQuote);
      for (int i = 0; i < flen; i++) begin
        if (quoted) begin
          b = ($urandom_range(0, 3) == 0) ? Specials[$urandom_range(0, 3)]
                                          : ByteW'($urandom_range(1, 255));
          put_byte(b);
          if (b == ChQuote) put_byte(ChQuote);
        end else begin
          put_byte(plain_byte(i == 0));
        end
      end
      if (quoted) begin
        if (f == nf - 1 && $urandom_range(0, 4) == 0) begin
          open_end = 1'b1;
        end else begin
          put_byte(ChQuote);
          if ($urandom_range(0, 11) == 0) put_byte(plain_byte(1'b1));
        end
      end
      if (f < nf - 1) put_byte(ChComma);
    end
    if (open_end) term = TERM_NUL;
    case (term)
      TERM_CR:   put_byte(ChCr);
      TERM_LF:   put_byte(ChLf);
      TERM_CRLF: begin
        put_byte(ChCr);
        put_byte(ChLf);
      end
      default: ;
    endcase
    // Skipped tail after a terminator
    if (term != TERM_NUL)
      repeat ($urandom_range(0, 3)) put_byte(ByteW'($urandom_range(1, 255)));
    put_byte(ChNul);
  endtask

  initial begin
    int unsigned phase, target, stop_idle;
    logic [ByteW-1:0] v;
    token_t t;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed table, starting from the reset value of max_field_len
    tx_idle  = 1'b1;
    rx_stall = 1'b1;
    foreach (DirRows[i]) begin
      if (DirRows[i].is_cfg) begin
        set_max_len(DirRows[i].val);
      end else begin
        t = '{DirRows[i].kind, DirRows[i].data, DirRows[i].len};
        put_byte(DirRows[i].val, DirRows[i].fixed, DirRows[i].yields, t);
      end
    end

    // Random phases over several limits, extremes first
    phase     = 0;
    stop_idle = n_items + (RandItems * 85) / 100;
    while (n_items < RandItems + NumDir) begin
      case (phase)
        0:       v = 8'd255;
        1:       v = 8'd0;
        2:       v = 8'd1;
        3:       v = 8'd254;
        4:       v = 8'd2;
        default: v = ($urandom_range(0, 1) == 0) ? ByteW'($urandom_range(0, 255))
                                                 : ByteW'($urandom_range(0, 6));
      endcase
      set_max_len(v);
      target = n_items + 110;
      if (max_len < 16 || max_len == 8'd255) send_record(1'b1);
      while (n_items < target) begin
        if (n_items >= stop_idle) begin
          tx_idle  = 1'b0;
          rx_stall = 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          tx_idle  = $urandom_range(0, 3) != 0;
          rx_stall = $urandom_range(0, 3) != 0;
        end
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 8)) put_byte(noisy_byte());
          if ($urandom_range(0, 1) == 0) put_byte(ChNul);
        end else begin
          send_record(1'b0);
        end
      end
      phase++;
    end

    drain();
    $display("Sent %0d items and checked %0d results across %0d max_field_len writes,",
             n_items, n_results, n_cfg);
    $display("covering quoted, unquoted, overlong and malformed fields.");
    if (n_errors == 0 && expected_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
